[design/assert_macros.svh]
// Assertion helpers included by the parser RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define LPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while in reset.
`define LPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/lpfcp_pkg.sv]
package lpfcp_pkg;

    // payload buffer depth
    localparam int PAYLOAD_MAX = 64;
    localparam int ADDR_W      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int FRAME_LEN_W = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [CRC_W-1:0]    t_crc;
    typedef logic [STATUS_W-1:0] t_status;

    // result status codes
    localparam t_status ST_GOOD    = 2'd0;
    localparam t_status ST_CRC_ERR = 2'd1;
    localparam t_status ST_LEN_ERR = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 2'd1;

    // one byte through CRC-16-CCITT, MSB first
    function automatic t_crc crc16_feed(input t_crc crc, input t_byte b);
        t_crc c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/length_prefixed_frame_crc_parser.sv]
// Frame parser for a byte stream: start byte, 16-bit big-endian length,
// payload, 16-bit big-endian CRC-16-CCITT over the payload.
// Input channel: i_valid / o_stall with i_rx_byte, one received byte a beat.
// Output channel: o_valid / i_stall with status, frame_len, data_byte,
// byte_valid and last; one result a beat from a single output register.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is the
// start byte, index 1 the CRC seed; other indexes are dropped.
// A status result (length too large, CRC mismatch, good empty frame) is
// shown the cycle after its byte.
// Good frame: payload is read back from the 64-byte buffer RAM, each
// result beat by a RAM read and then the output register; a new read waits
// for the last beat to land. Other bytes go one a cycle.
// Input is held off during a burst, and while an unread result sits in the
// output register and the next byte might make another result.
// When the receiver stalls the output register holds its beat unchanged.
// Reset (synchronous, active low): parser hunts for the start byte, start
// byte 0x7E, seed 0xFFFF, no result pending. The buffer is not cleared; only
// bytes written in the current frame are read back.
module length_prefixed_frame_crc_parser
    import lpfcp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte input
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_rx_byte,
    // results
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [6:0]             o_frame_len,
    output logic [7:0]             o_data_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    `include "assert_macros.svh"

    // parser phases; codes above CRC_LO behave as WAIT
    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;

    // config
    t_byte r_start_byte;
    t_crc  r_crc_seed;

    // parser state
    logic [2:0]       r_phase;
    t_byte            r_len_high;
    logic [LEN_W-1:0] r_expected_len;
    logic [LEN_W-1:0] r_byte_count;
    t_crc             r_crc;
    t_byte            r_crc_high;

    // burst read-back
    logic             r_burst;
    logic             r_rd_pend;
    logic             r_rd_last;
    logic [LEN_W-1:0] r_rd_idx;

    // output register
    logic             r_out_valid;
    t_status          r_out_status;
    logic [6:0]       r_out_len;
    t_byte            r_out_data;
    logic             r_out_bv;
    logic             r_out_last;

    logic             in_fire;
    logic             out_fire;
    logic             rd_issue;
    logic             ram_we;
    t_byte            ram_rdata;
    t_crc             n_crc;
    logic [LEN_W-1:0] n_byte_count;
    logic [LEN_W-1:0] n_rd_idx;
    logic [15:0]      rx_len;
    logic             len_too_big;
    t_crc             rx_crc;
    logic             result_phase;

    // -------------------------------------------------------------------
    // handshakes
    // -------------------------------------------------------------------
    // Only the LEN_LO and CRC_LO bytes can make a result, so only those
    // wait for the output register to drain.
    assign result_phase = (r_phase == PH_LEN_LO) || (r_phase == PH_CRC_LO);
    assign o_stall      = r_burst || r_rd_pend || (r_out_valid && result_phase);
    assign in_fire      = i_valid && !o_stall;
    assign out_fire     = r_out_valid && !i_stall;
    assign o_cfg_ready  = 1'b1;

    // a burst read goes out only when its beat is sure to find the output
    // register free when it lands
    assign rd_issue = r_burst && !r_rd_pend && (!r_out_valid || !i_stall);
    assign n_rd_idx = r_rd_idx + 1'b1;

    assign n_crc        = crc16_feed(r_crc, i_rx_byte);
    assign n_byte_count = r_byte_count + 1'b1;
    assign rx_len       = {r_len_high, i_rx_byte};
    assign len_too_big  = rx_len > 16'(PAYLOAD_MAX);
    assign rx_crc       = {r_crc_high, i_rx_byte};
    assign ram_we       = in_fire && (r_phase == PH_PAYLOAD);

    // -------------------------------------------------------------------
    // payload buffer
    // -------------------------------------------------------------------
    lpfcp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_byte_count[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // -------------------------------------------------------------------
    // config registers
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'h7E;
            r_crc_seed   <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_BYTE: r_start_byte <= i_cfg_data[7:0];
                CFG_CRC_SEED:   r_crc_seed   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // -------------------------------------------------------------------
    // parser, burst sequencer and output register
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT;
            r_len_high     <= '0;
            r_expected_len <= '0;
            r_byte_count   <= '0;
            r_crc          <= 16'hFFFF;
            r_crc_high     <= '0;
            r_burst        <= 1'b0;
            r_rd_pend      <= 1'b0;
            r_rd_last      <= 1'b0;
            r_rd_idx       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            // burst: issue read, then land the beat
            if (rd_issue) begin
                r_rd_pend <= 1'b1;
                r_rd_idx  <= n_rd_idx;
                r_rd_last <= (n_rd_idx == r_expected_len);
                if (n_rd_idx == r_expected_len) begin
                    r_burst <= 1'b0;
                end
            end else if (r_rd_pend) begin
                r_rd_pend <= 1'b0;
            end

            if (r_rd_pend) begin
                r_out_valid  <= 1'b1;
                r_out_status <= ST_GOOD;
                r_out_len    <= FRAME_LEN_W'(r_expected_len);
                r_out_data   <= ram_rdata;
                r_out_bv     <= 1'b1;
                r_out_last   <= r_rd_last;
            end

            if (in_fire) begin
                case (r_phase)
                    PH_LEN_HI: begin
                        r_len_high <= i_rx_byte;
                        r_phase    <= PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (len_too_big) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_LEN_ERR;
                            r_out_len    <= '0;
                            r_out_data   <= '0;
                            r_out_bv     <= 1'b0;
                            r_out_last   <= 1'b1;
                            r_phase      <= PH_WAIT;
                        end else begin
                            r_expected_len <= LEN_W'(rx_len);
                            r_byte_count   <= '0;
                            r_phase <= (rx_len == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        r_crc        <= n_crc;
                        r_byte_count <= n_byte_count;
                        if (n_byte_count >= r_expected_len) begin
                            r_phase <= PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        r_crc_high <= i_rx_byte;
                        r_phase    <= PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        r_phase <= PH_WAIT;
                        if (rx_crc == r_crc && r_expected_len != '0) begin
                            // good frame with payload: start read-back
                            r_burst  <= 1'b1;
                            r_rd_idx <= '0;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= (rx_crc == r_crc) ? ST_GOOD : ST_CRC_ERR;
                            r_out_len    <= '0;
                            r_out_data   <= '0;
                            r_out_bv     <= 1'b0;
                            r_out_last   <= 1'b1;
                        end
                    end
                    default: begin
                        if (i_rx_byte == r_start_byte) begin
                            r_phase      <= PH_LEN_HI;
                            r_byte_count <= '0;
                            r_crc        <= r_crc_seed;
                        end else begin
                            r_phase <= PH_WAIT;
                        end
                    end
                endcase
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_frame_len  = r_out_len;
    assign o_data_byte  = r_out_data;
    assign o_byte_valid = r_out_bv;
    assign o_last       = r_out_last;

    // -------------------------------------------------------------------
    // checks
    // -------------------------------------------------------------------
    `LPF_ASSERT_NXT(a_rd_lands, r_rd_pend, r_out_valid && r_out_bv)
    `LPF_ASSERT_IMP(a_bv_good, r_out_valid && r_out_bv, r_out_status == ST_GOOD)
    `LPF_ASSERT_IMP(a_burst_idle_parser, r_burst || r_rd_pend, r_phase == PH_WAIT)
    `LPF_ASSERT_IMP(a_payload_in_range, r_phase == PH_PAYLOAD,
                    r_byte_count < r_expected_len)

endmodule

[design/lpfcp_ram.sv]
module lpfcp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sv/length_prefixed_frame_crc_parser_tb.sv]
`default_nettype none

module length_prefixed_frame_crc_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfcp_pkg::*;

    // run shaping
    localparam int RAND_BEATS   = 180;  // framed input beats in the random part
    localparam int PHASE_BEATS  = RAND_BEATS / 5;  // framed beats between register changes
    localparam int CALM_FROM    = 145;  // no idling on either side after this
    localparam int HOLD_CYCLES  = 150;  // one long receiver hold-off
    localparam int SETTLE_CYCLES = 8;   // quiet time before a register write
    localparam int TAIL_CYCLES  = 40;   // watch for stray beats at the end
    localparam int PRINT_CAP    = 60;

    // spare register indexes, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [15:0] LEN_LIMIT = 16'(PAYLOAD_MAX);

    // one result beat, fields in port order
    typedef struct packed {
        t_status    status;
        logic [6:0] frame_len;
        t_byte      data_byte;
        logic       byte_valid;
        logic       last;
    } t_beat;

    localparam t_beat NO_BEAT      = '0;
    localparam t_beat BEAT_EMPTY_OK = {ST_GOOD,    7'd0, 8'd0, 1'b0, 1'b1};
    localparam t_beat BEAT_CRC_ERR  = {ST_CRC_ERR, 7'd0, 8'd0, 1'b0, 1'b1};
    localparam t_beat BEAT_LEN_ERR  = {ST_LEN_ERR, 7'd0, 8'd0, 1'b0, 1'b1};

    // how a stimulus byte is formed; for the CRC roles val is an xor mask
    typedef enum logic [2:0] {
        ROLE_PLAIN, ROLE_START, ROLE_DATA, ROLE_CRC_HI, ROLE_CRC_LO
    } t_role;

    typedef struct packed {
        t_role role;
        t_byte val;
        logic  typed;   // want holds the expected beat, else predicted
        t_beat want;
    } t_row;

    // parser phases as seen by the predictor
    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_FCS_HI, PH_FCS_LO
    } t_rx_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_status;
    logic [6:0]           o_frame_len;
    logic [7:0]           o_data_byte;
    logic                 o_byte_valid;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    // travels alongside the byte on offer, so the monitor sees it on acceptance
    logic  byte_typed = 1'b0;
    t_beat byte_want  = '0;

    length_prefixed_frame_crc_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_frame_len  (o_frame_len),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers plus a private copy of the parser
    // ------------------------------------------------------------------
    t_byte      reg_start = 8'h7E;
    t_crc       reg_seed  = 16'hFFFF;
    t_rx_phase  rx_phase  = PH_HUNT;
    t_byte      len_hi    = '0;
    logic [6:0] want_len  = '0;
    logic [6:0] body_count = '0;
    t_crc       frame_crc = 16'hFFFF;
    t_byte      fcs_hi    = '0;
    t_byte      body_store [PAYLOAD_MAX];

    t_beat frame_beats_due [$];   // beats the block still owes, oldest first
    int    mismatches = 0;

    // stimulus side: its own idea of the registers and of the frame's CRC
    t_byte gen_start = 8'h7E;
    t_crc  gen_seed  = 16'hFFFF;
    t_crc  gen_crc   = 16'hFFFF;
    int    big_left  = 3;
    bit    calm        = 1'b0;
    bit    pressure_on = 1'b0;

    // CRC-16-CCITT, one input bit at a time, MSB first
    function automatic t_crc ccitt_byte(input t_crc acc, input t_byte b);
        t_crc r;
        logic fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // advance the parser copy by one accepted byte; keep=0 drops the beats
    // (the row carries its own expectation)
    function automatic void parse_rx_byte(input t_byte b, input bit keep);
        case (rx_phase)
            PH_LEN_HI: begin
                len_hi   = b;
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if ({len_hi, b} > LEN_LIMIT) begin
                    if (keep) frame_beats_due.push_back(BEAT_LEN_ERR);
                    rx_phase = PH_HUNT;
                end else begin
                    want_len   = b[6:0];
                    body_count = '0;
                    rx_phase   = (b == 8'd0) ? PH_FCS_HI : PH_BODY;
                end
            end
            PH_BODY: begin
                body_store[body_count[ADDR_W-1:0]] = b;
                frame_crc  = ccitt_byte(frame_crc, b);
                body_count = body_count + 7'd1;
                if (body_count >= want_len) rx_phase = PH_FCS_HI;
            end
            PH_FCS_HI: begin
                fcs_hi   = b;
                rx_phase = PH_FCS_LO;
            end
            PH_FCS_LO: begin
                if ({fcs_hi, b} != frame_crc) begin
                    if (keep) frame_beats_due.push_back(BEAT_CRC_ERR);
                end else if (want_len == 7'd0) begin
                    if (keep) frame_beats_due.push_back(BEAT_EMPTY_OK);
                end else if (keep) begin
                    for (int i = 0; i < want_len; i++) begin
                        frame_beats_due.push_back({ST_GOOD, want_len, body_store[i],
                                                   1'b1, (i == want_len - 1)});
                    end
                end
                rx_phase = PH_HUNT;
            end
            default: begin
                // anything but the start byte is line noise here
                if (b == reg_start) begin
                    rx_phase   = PH_LEN_HI;
                    body_count = '0;
                    frame_crc  = reg_seed;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Monitor: all three channels sampled on the rising edge. Output is
    // checked before the input beat of the same edge is predicted, since a
    // byte cannot produce a result in the cycle it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_status, o_frame_len, o_data_byte, o_byte_valid, o_last};
                if (frame_beats_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat st=%0d len=%0d data=%02h",
                                            got.status, got.frame_len, got.data_byte));
                end else begin
                    want = frame_beats_due.pop_front();
                    if (got !== want) begin
                        flag_mismatch($sformatf(
                            {"got st=%0d len=%0d data=%02h bv=%0b last=%0b, ",
                             "want %0d %0d %02h %0b %0b"},
                            got.status, got.frame_len, got.data_byte, got.byte_valid, got.last,
                            want.status, want.frame_len, want.data_byte, want.byte_valid,
                            want.last));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_BYTE) reg_start = i_cfg_data[7:0];
                else if (i_cfg_index == CFG_CRC_SEED) reg_seed = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                parse_rx_byte(i_rx_byte, !byte_typed);
                if (byte_typed) frame_beats_due.push_back(byte_want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    // offer one byte, hold it until taken, then maybe go quiet for a burst
    task automatic send_role(input t_role role, input t_byte val, input logic typed,
                             input t_beat want);
        t_byte b;
        case (role)
            ROLE_START: begin
                b       = val;
                gen_crc = gen_seed;
            end
            ROLE_DATA: begin
                b       = val;
                gen_crc = ccitt_byte(gen_crc, val);
            end
            ROLE_CRC_HI: b = gen_crc[15:8] ^ val;
            ROLE_CRC_LO: b = gen_crc[7:0] ^ val;
            default:     b = val;
        endcase
        i_rx_byte  <= b;
        i_valid    <= 1'b1;
        byte_typed <= typed;
        byte_want  <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!calm && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // well-formed frame; flip is xored into the transmitted CRC
    task automatic send_frame(input int n, input t_crc flip);
        logic [15:0] len16;
        t_byte       d;
        len16 = 16'(n);
        send_role(ROLE_START, gen_start, 1'b0, NO_BEAT);
        send_role(ROLE_PLAIN, len16[15:8], 1'b0, NO_BEAT);
        send_role(ROLE_PLAIN, len16[7:0], 1'b0, NO_BEAT);
        for (int i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 255));
            send_role(ROLE_DATA, d, 1'b0, NO_BEAT);
        end
        send_role(ROLE_CRC_HI, flip[15:8], 1'b0, NO_BEAT);
        send_role(ROLE_CRC_LO, flip[7:0], 1'b0, NO_BEAT);
    endtask

    // mostly good frames; the rest bad CRC, oversize length, noise, cut-off frames
    task automatic send_random_frame(output int beats);
        int          roll;
        int          n;
        logic [15:0] len16;
        t_byte       b;
        roll  = $urandom_range(0, 99);
        beats = 0;
        if (roll < 55 || (roll < 62 && big_left == 0)) begin
            n = $urandom_range(1, 8);
            send_frame(n, 16'h0000);
            beats = n + 5;
        end else if (roll < 62) begin
            // a few long frames, the full buffer first
            n = (big_left > 1) ? PAYLOAD_MAX : $urandom_range(9, PAYLOAD_MAX - 1);
            big_left--;
            send_frame(n, 16'h0000);
            beats = n + 5;
        end else if (roll < 70) begin
            send_frame(0, 16'h0000);
            beats = 5;
        end else if (roll < 80) begin
            n = $urandom_range(0, 8);
            send_frame(n, 16'h0001 << $urandom_range(0, 15));
            beats = n + 5;
        end else if (roll < 87) begin
            if ($urandom_range(0, 1) == 1) begin
                len16[15:8] = 8'($urandom_range(1, 255));
                len16[7:0]  = 8'($urandom_range(0, 255));
            end else begin
                len16 = 16'($urandom_range(PAYLOAD_MAX + 1, 255));
            end
            send_role(ROLE_START, gen_start, 1'b0, NO_BEAT);
            send_role(ROLE_PLAIN, len16[15:8], 1'b0, NO_BEAT);
            send_role(ROLE_PLAIN, len16[7:0], 1'b0, NO_BEAT);
            beats = 3;
        end else if (roll < 94) begin
            // line noise, not counted
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                send_role(ROLE_PLAIN, b, 1'b0, NO_BEAT);
            end
        end else begin
            // frame cut short; whatever follows is parsed as its remainder
            n = $urandom_range(1, 3);
            send_role(ROLE_START, gen_start, 1'b0, NO_BEAT);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                send_role(ROLE_PLAIN, b, 1'b0, NO_BEAT);
            end
            beats = n + 1;
        end
    endtask

    // stop sending and let every owed beat come out, then some quiet cycles
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (frame_beats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_valid after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_START_BYTE) gen_start = data[7:0];
        else if (idx == CFG_CRC_SEED) gen_seed = data;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: short random stalls, one long hold-off so the
    // block backs up and stalls its input, then none near the end.
    // ------------------------------------------------------------------
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pressure_on && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 15) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row  dir_rows [$];
        int    frame_beats;
        int    beats;
        t_byte rb;
        frame_beats = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes, reset register values (start 0x7E, seed 0xFFFF)
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});       // noise
        dir_rows.push_back({ROLE_START, 8'h7E, 1'b0, NO_BEAT});       // empty frame
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'hFF, 1'b0, NO_BEAT});       // CRC = seed
        dir_rows.push_back({ROLE_PLAIN, 8'hFF, 1'b1, BEAT_EMPTY_OK});
        dir_rows.push_back({ROLE_START, 8'h7E, 1'b0, NO_BEAT});       // one past max
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'h41, 1'b1, BEAT_LEN_ERR});
        dir_rows.push_back({ROLE_START, 8'h7E, 1'b0, NO_BEAT});       // length 0xFFFF
        dir_rows.push_back({ROLE_PLAIN, 8'hFF, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'hFF, 1'b1, BEAT_LEN_ERR});
        dir_rows.push_back({ROLE_START, 8'h7E, 1'b0, NO_BEAT});       // start byte as data
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'h02, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_DATA,  8'h7E, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_DATA,  8'hA5, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_CRC_HI, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_CRC_LO, 8'h00, 1'b0, NO_BEAT});      // two good beats
        dir_rows.push_back({ROLE_START, 8'h7E, 1'b0, NO_BEAT});       // bad CRC, 1 byte
        dir_rows.push_back({ROLE_PLAIN, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_PLAIN, 8'h01, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_DATA,  8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_CRC_HI, 8'h00, 1'b0, NO_BEAT});
        dir_rows.push_back({ROLE_CRC_LO, 8'h01, 1'b1, BEAT_CRC_ERR});

        foreach (dir_rows[k]) begin
            send_role(dir_rows[k].role, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].want);
        end
        drain_results();

        // random part in five register settings; the receiver's long
        // hold-off lands early in the first one
        pressure_on = 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: begin
                        write_reg(CFG_START_BYTE, 16'h0000);
                        write_reg(CFG_CRC_SEED, 16'h0000);
                    end
                    2: begin
                        rb = 8'($urandom_range(0, 255));
                        write_reg(CFG_START_BYTE, {rb, 8'hFF});
                        write_reg(CFG_SPARE_A, 16'h0000);
                        write_reg(CFG_CRC_SEED, 16'hFFFF);
                    end
                    3: begin
                        write_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
                        write_reg(CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
                        write_reg(CFG_START_BYTE, 16'($urandom_range(0, 65535)));
                    end
                    default: begin
                        write_reg(CFG_START_BYTE, 16'h007E);
                        write_reg(CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
                    end
                endcase
                i_cfg_valid <= 1'b0;
            end
            while (frame_beats < (ph + 1) * PHASE_BEATS) begin
                calm = (frame_beats >= CALM_FROM);
                send_random_frame(beats);
                frame_beats += beats;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("length_prefixed_frame_crc_parser_tb OK");
        end else begin
            $display("length_prefixed_frame_crc_parser_tb NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("length_prefixed_frame_crc_parser_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
